@@ design/lc3_pkg.sv @@
// Package for the LC-3 instruction core: action codes, opcodes, queue entry,
// result and back-end state types. No dependencies.
package lc3_pkg;

	typedef enum logic [1:0] {
		ACT_ORIGIN = 2'd0,
		ACT_LOAD   = 2'd1,
		ACT_STEP   = 2'd2,
		ACT_READ   = 2'd3
	} action_t;

	localparam logic [3:0] OP_BR   = 4'h0;
	localparam logic [3:0] OP_ADD  = 4'h1;
	localparam logic [3:0] OP_LD   = 4'h2;
	localparam logic [3:0] OP_ST   = 4'h3;
	localparam logic [3:0] OP_JSR  = 4'h4;
	localparam logic [3:0] OP_AND  = 4'h5;
	localparam logic [3:0] OP_LDR  = 4'h6;
	localparam logic [3:0] OP_STR  = 4'h7;
	localparam logic [3:0] OP_NOT  = 4'h9;
	localparam logic [3:0] OP_LDI  = 4'hA;
	localparam logic [3:0] OP_STI  = 4'hB;
	localparam logic [3:0] OP_JMP  = 4'hC;
	localparam logic [3:0] OP_LEA  = 4'hE;

	localparam logic [3:0]  NO_REG     = 4'd8;
	localparam logic [15:0] MEM_RESET  = 16'hFD00;
	localparam logic [15:0] END_PC     = 16'hFFFF;

	// One classified item on its way from the front part to the back part.
	typedef struct packed {
		action_t     action;
		logic [15:0] data;
		logic [15:0] address;
	} entry_t;

	typedef struct packed {
		logic [15:0] read_data;
		logic [15:0] pc;
		logic [15:0] instruction;
		logic [3:0]  write_reg;
		logic [15:0] write_value;
		logic [2:0]  cond_flags;
		logic        at_end;
	} result_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FETCH,
		ST_EXEC,
		ST_INDIR,
		ST_DATA,
		ST_CLEAR,
		ST_OUT
	} state_t;

	// Sign extension of the low bits of an instruction word.
	function automatic logic [15:0] sext9(input logic [15:0] w);
		sext9 = {{7{w[8]}}, w[8:0]};
	endfunction
	function automatic logic [15:0] sext11(input logic [15:0] w);
		sext11 = {{5{w[10]}}, w[10:0]};
	endfunction
	function automatic logic [15:0] sext6(input logic [15:0] w);
		sext6 = {{10{w[5]}}, w[5:0]};
	endfunction
	function automatic logic [15:0] sext5(input logic [15:0] w);
		sext5 = {{11{w[4]}}, w[4:0]};
	endfunction

	function automatic logic [2:0] flags_of(input logic [15:0] v);
		if (v == 16'd0)
			flags_of = 3'b010;
		else if (v[15])
			flags_of = 3'b100;
		else
			flags_of = 3'b001;
	endfunction

endpackage

@@ design/lc3_stream_if.sv @@
// Valid/ready stream interface carrying one payload of a given type.
// Depends on nothing; the payload type is a parameter.
interface lc3_stream_if #(parameter type payload_t = logic) (input logic clk);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

@@ design/lc3_front.sv @@
// Front part: takes input transfers and queues them for the back part.
// Depends on lc3_pkg and lc3_stream_if.
module lc3_front #(
	parameter int DEPTH_BITS = 1
) (
	input  logic           clk,
	input  logic           arst_n,
	lc3_stream_if.sink     in_ch,
	output lc3_pkg::entry_t head,
	output logic           head_valid,
	input  logic           head_pop
);
	localparam int DEPTH = 1 << DEPTH_BITS;

	lc3_pkg::entry_t       queue_q [DEPTH];
	logic [DEPTH_BITS-1:0] wr_ptr_q, rd_ptr_q;
	logic [DEPTH_BITS:0]   count_q;
	logic                  push;
	logic                  pop;

	assign in_ch.ready = (count_q != DEPTH[DEPTH_BITS:0]);
	assign push        = in_ch.valid && in_ch.ready;
	assign head_valid  = (count_q != '0);
	assign pop         = head_pop && head_valid;
	assign head        = queue_q[rd_ptr_q];

	// Queue storage; the payload needs no reset.
	always_ff @(posedge clk) begin
		if (push)
			queue_q[wr_ptr_q] <= in_ch.payload;
	end

	// Queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end
endmodule

@@ design/lc3_back.sv @@
// Back part: sequencer that executes queued actions against the word memory
// and register file and presents results. Depends on lc3_pkg, lc3_stream_if.
module lc3_back #(
	parameter int ADDR_BITS = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  lc3_pkg::entry_t head,
	input  logic            head_valid,
	output logic            head_pop,
	lc3_stream_if.source    out_ch
);
	localparam int WORDS = 1 << ADDR_BITS;

	logic [15:0] mem [WORDS];
	logic [15:0] regs_q [8];
	logic [15:0] pc_q, lp_q;
	logic [2:0]  flags_q;
	lc3_pkg::state_t state_q, state_d;
	logic [ADDR_BITS-1:0] clr_q;
	logic        clr_done_q;

	lc3_pkg::entry_t ent_q;
	logic [15:0] instr_q, rdata_q;
	lc3_pkg::result_t res_q;
	logic        out_valid_q;

	// Memory port controls, set by the sequencer.
	logic                 mem_we;
	logic [ADDR_BITS-1:0] mem_wa, mem_ra;
	logic [15:0]          mem_wd;

	// Decode fields of the current instruction.
	logic [3:0]  op;
	logic [2:0]  dr, sr1, sr2;
	logic [15:0] src1, src2, opnd_b, pcoff9, regoff6, jsr_tgt;

	assign op      = instr_q[15:12];
	assign dr      = instr_q[11:9];
	assign sr1     = instr_q[8:6];
	assign sr2     = instr_q[2:0];
	assign src1    = regs_q[sr1];
	assign src2    = regs_q[dr];
	assign opnd_b  = instr_q[5] ? lc3_pkg::sext5(instr_q) : regs_q[sr2];
	assign pcoff9  = pc_q + lc3_pkg::sext9(instr_q);
	assign regoff6 = src1 + lc3_pkg::sext6(instr_q);
	assign jsr_tgt = instr_q[11] ? pc_q + lc3_pkg::sext11(instr_q) : src1;

	// Memory with one write port and one read port; the read data is registered.
	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_wa] <= mem_wd;
		rdata_q <= mem[mem_ra];
	end

	assign out_ch.valid   = out_valid_q;
	assign out_ch.payload = res_q;

	// Next state and memory controls.
	always_comb begin
		state_d  = state_q;
		head_pop = 1'b0;
		mem_we   = 1'b0;
		mem_wa   = lp_q[ADDR_BITS-1:0];
		mem_wd   = ent_q.data;
		mem_ra   = pc_q[ADDR_BITS-1:0];
		case (state_q)
			lc3_pkg::ST_CLEAR: begin
				mem_we = 1'b1;
				mem_wa = clr_q;
				mem_wd = lc3_pkg::MEM_RESET;
				if (clr_done_q)
					state_d = lc3_pkg::ST_IDLE;
			end
			lc3_pkg::ST_IDLE: begin
				if (head_valid && (!out_valid_q || out_ch.ready)) begin
					head_pop = 1'b1;
					mem_ra   = (head.action == lc3_pkg::ACT_READ) ?
						head.address[ADDR_BITS-1:0] : pc_q[ADDR_BITS-1:0];
					state_d  = (head.action == lc3_pkg::ACT_STEP) ?
						lc3_pkg::ST_FETCH : lc3_pkg::ST_OUT;
				end
			end
			lc3_pkg::ST_FETCH: state_d = lc3_pkg::ST_EXEC;
			lc3_pkg::ST_EXEC: begin
				state_d = lc3_pkg::ST_OUT;
				case (op)
					lc3_pkg::OP_LD, lc3_pkg::OP_LDI, lc3_pkg::OP_STI: begin
						mem_ra  = pcoff9[ADDR_BITS-1:0];
						state_d = (op == lc3_pkg::OP_LD) ? lc3_pkg::ST_DATA
							: lc3_pkg::ST_INDIR;
					end
					lc3_pkg::OP_LDR: begin
						mem_ra  = regoff6[ADDR_BITS-1:0];
						state_d = lc3_pkg::ST_DATA;
					end
					lc3_pkg::OP_ST: begin
						mem_we = 1'b1;
						mem_wa = pcoff9[ADDR_BITS-1:0];
						mem_wd = src2;
					end
					lc3_pkg::OP_STR: begin
						mem_we = 1'b1;
						mem_wa = regoff6[ADDR_BITS-1:0];
						mem_wd = src2;
					end
					default: ;
				endcase
			end
			lc3_pkg::ST_INDIR: begin
				if (op == lc3_pkg::OP_STI) begin
					mem_we  = 1'b1;
					mem_wa  = rdata_q[ADDR_BITS-1:0];
					mem_wd  = src2;
					state_d = lc3_pkg::ST_OUT;
				end else begin
					mem_ra  = rdata_q[ADDR_BITS-1:0];
					state_d = lc3_pkg::ST_DATA;
				end
			end
			lc3_pkg::ST_DATA: state_d = lc3_pkg::ST_OUT;
			lc3_pkg::ST_OUT: begin
				state_d = lc3_pkg::ST_IDLE;
				if (ent_q.action == lc3_pkg::ACT_LOAD)
					mem_we = 1'b1;
			end
			default: state_d = lc3_pkg::ST_IDLE;
		endcase
	end

	// Architectural state, result register and sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lc3_pkg::ST_CLEAR;
			clr_q       <= '0;
			clr_done_q  <= 1'b0;
			pc_q        <= '0;
			lp_q        <= '0;
			flags_q     <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < 8; i++)
				regs_q[i] <= '0;
		end else begin
			state_q <= state_d;
			// A new result is presented from the output state; otherwise the
			// held result leaves on its transfer.
			if (state_q == lc3_pkg::ST_OUT)
				out_valid_q <= 1'b1;
			else if (out_ch.ready)
				out_valid_q <= 1'b0;
			case (state_q)
				lc3_pkg::ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == {ADDR_BITS{1'b1}} - 1'b1)
						clr_done_q <= 1'b1;
				end
				lc3_pkg::ST_IDLE: begin
					if (head_pop) begin
						ent_q   <= head;
						instr_q <= '0;
						res_q.write_reg   <= lc3_pkg::NO_REG;
						res_q.write_value <= '0;
						res_q.read_data   <= '0;
					end
				end
				lc3_pkg::ST_FETCH: begin
					instr_q <= rdata_q;
					pc_q    <= pc_q + 16'd1;
				end
				lc3_pkg::ST_EXEC: begin
					case (op)
						lc3_pkg::OP_BR:
							if ((dr & flags_q) != 3'd0)
								pc_q <= pcoff9;
						lc3_pkg::OP_ADD, lc3_pkg::OP_AND, lc3_pkg::OP_NOT: begin
							logic [15:0] v;
							v = (op == lc3_pkg::OP_ADD) ? src1 + opnd_b :
								(op == lc3_pkg::OP_AND) ? (src1 & opnd_b) : ~src1;
							regs_q[dr]        <= v;
							flags_q           <= lc3_pkg::flags_of(v);
							res_q.write_reg   <= {1'b0, dr};
							res_q.write_value <= v;
						end
						lc3_pkg::OP_JSR: begin
							pc_q              <= jsr_tgt;
							regs_q[7]         <= pc_q;
							res_q.write_reg   <= 4'd7;
							res_q.write_value <= pc_q;
						end
						lc3_pkg::OP_JMP: pc_q <= src1;
						lc3_pkg::OP_LEA: begin
							regs_q[dr]        <= pcoff9;
							res_q.write_reg   <= {1'b0, dr};
							res_q.write_value <= pcoff9;
						end
						default: ;
					endcase
				end
				lc3_pkg::ST_DATA: begin
					regs_q[dr]        <= rdata_q;
					flags_q           <= lc3_pkg::flags_of(rdata_q);
					res_q.write_reg   <= {1'b0, dr};
					res_q.write_value <= rdata_q;
				end
				lc3_pkg::ST_OUT: begin
					logic [15:0] npc;
					npc = pc_q;
					case (ent_q.action)
						lc3_pkg::ACT_ORIGIN: begin
							npc  = ent_q.data;
							lp_q <= ent_q.data;
						end
						lc3_pkg::ACT_LOAD: lp_q <= lp_q + 16'd1;
						lc3_pkg::ACT_READ: res_q.read_data <= rdata_q;
						default: ;
					endcase
					pc_q              <= npc;
					res_q.pc          <= npc;
					res_q.instruction <= instr_q;
					res_q.cond_flags  <= flags_q;
					res_q.at_end      <= (npc == lc3_pkg::END_PC);
				end
				default: ;
			endcase
		end
	end
endmodule

@@ design/lc3_instruction_core.sv @@
// Top level of the LC-3 instruction core: front queue plus executing back part.
// Depends on lc3_pkg, lc3_stream_if, lc3_front and lc3_back.
//
// Each input transfer (set origin, load word, step, read) yields one result
// transfer. After reset the word memory is swept to 0xFD00, one word a cycle;
// no item is taken from the queue until the sweep ends. Set origin, load word
// and read go from idle straight to the output state; a step passes through
// fetch and execute, plus a data state for LD and LDR, an indirect one for
// STI and both for LDI: fetch, data and indirect access take turns at memory.
// A two-entry queue lets input transfers continue while the back part works.
module lc3_instruction_core #(
	parameter int ADDR_BITS = 16
) (
	input logic          clk,
	input logic          arst_n,
	lc3_stream_if.sink   in_ch,
	lc3_stream_if.source out_ch
);
	lc3_pkg::entry_t head;
	logic            head_valid;
	logic            head_pop;

	lc3_front #(.DEPTH_BITS(1)) u_front (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch),
		.head(head), .head_valid(head_valid), .head_pop(head_pop)
	);

	lc3_back #(.ADDR_BITS(ADDR_BITS)) u_back (
		.clk(clk), .arst_n(arst_n), .head(head), .head_valid(head_valid),
		.head_pop(head_pop), .out_ch(out_ch)
	);
endmodule
